// ----- design/pest_pkg.sv -----
// shared types, codes and scaling tables for the pointer event state tracker
// used by pest_apb_regs, pest_front, pest_state and the top level
package pest_pkg;

  // event operation codes
  localparam logic [2:0] OP_MOTION = 3'd0;
  localparam logic [2:0] OP_BUTTON = 3'd1;
  localparam logic [2:0] OP_CONT   = 3'd2;
  localparam logic [2:0] OP_DISC   = 3'd3;
  localparam logic [2:0] OP_V120   = 3'd4;
  localparam logic [2:0] OP_FRAME  = 3'd5;
  localparam logic [2:0] OP_POLL   = 3'd6;

  // evdev button codes
  localparam logic [9:0] CODE_LEFT   = 10'h110;
  localparam logic [9:0] CODE_RIGHT  = 10'h111;
  localparam logic [9:0] CODE_MIDDLE = 10'h112;

  localparam logic [1:0] IDX_LEFT   = 2'd0;
  localparam logic [1:0] IDX_RIGHT  = 2'd1;
  localparam logic [1:0] IDX_MIDDLE = 2'd2;
  localparam int unsigned NUM_BTN = 3;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam logic        REG_AUTO_RELEASE = 1'b0;
  localparam logic [7:0]  AUTO_RELEASE_RESET = 8'd3;

  // reciprocals: floor(m/5) = (m*RECIP5)>>34, floor(m/15) = (m*RECIP15)>>35
  localparam logic [31:0] RECIP5  = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP15 = 32'h8888_8889;

  typedef enum logic [2:0] {
    K_NONE,
    K_MOTION,
    K_BUTTON,
    K_CONT,
    K_DISC,
    K_FRAME,
    K_POLL
  } kind_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] pos_x_fixed;
    logic signed [31:0] pos_y_fixed;
    logic [9:0]         button_code;
    logic               pressed;
    logic               scroll_axis;
    logic signed [31:0] scroll_amount;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [1:0]         btn_idx;
    logic               pressed;
    logic signed [48:0] delta;
  } mid_t;

  typedef struct packed {
    logic accept;
    logic in_open;
    logic mid_open;
  } pipe_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic mid_valid;
    logic mid_poll;
  } front_stat_t;

  // floor(r*128/5) for remainders of a division by 5
  function automatic logic [6:0] frac5(input logic [2:0] r);
    logic [6:0] v;
    case (r)
      3'd0:    v = 7'd0;
      3'd1:    v = 7'd25;
      3'd2:    v = 7'd51;
      3'd3:    v = 7'd76;
      3'd4:    v = 7'd102;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  // floor(r*8192/15) for remainders of a division by 15
  function automatic logic [12:0] frac15(input logic [3:0] r);
    logic [12:0] v;
    case (r)
      4'd0:    v = 13'd0;
      4'd1:    v = 13'd546;
      4'd2:    v = 13'd1092;
      4'd3:    v = 13'd1638;
      4'd4:    v = 13'd2184;
      4'd5:    v = 13'd2730;
      4'd6:    v = 13'd3276;
      4'd7:    v = 13'd3822;
      4'd8:    v = 13'd4369;
      4'd9:    v = 13'd4915;
      4'd10:   v = 13'd5461;
      4'd11:   v = 13'd6007;
      4'd12:   v = 13'd6553;
      4'd13:   v = 13'd7099;
      4'd14:   v = 13'd7645;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/pest_apb_regs.sv -----
// configuration register block: auto-release poll count behind an apb-style port
// depends on pest_pkg
module pest_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pest_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [7:0]                  auto_release_o
);

  logic [7:0] auto_release_q;
  logic       hit;

  assign hit    = (paddr[2] == pest_pkg::REG_AUTO_RELEASE);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_release_q <= pest_pkg::AUTO_RELEASE_RESET;
    end else if (psel && penable && pwrite && hit) begin
      auto_release_q <= pwdata[7:0];
    end
  end

  assign prdata         = hit ? {24'd0, auto_release_q} : 32'd0;
  assign auto_release_o = auto_release_q;

endmodule

// ----- design/pest_front.sv -----
// front stage: input register, event decode and scroll scaling into the mid register
// depends on pest_pkg
module pest_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pest_pkg::pipe_ctl_t    ctl_i,
  input  pest_pkg::item_t        item_i,
  output pest_pkg::front_stat_t  stat_o,
  output pest_pkg::mid_t         mid_o
);

  logic            in_valid_q;
  pest_pkg::item_t in_q;
  logic            mid_valid_q;
  pest_pkg::mid_t  mid_q;
  pest_pkg::mid_t  mid_d;

  logic               neg;
  logic [31:0]        mag_in;
  logic [31:0]        recip;
  logic [63:0]        prod;
  logic [29:0]        q5;
  logic [28:0]        q15;
  logic [2:0]         r5;
  logic [3:0]         r15;
  logic [47:0]        mag;
  logic               vertical;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
    end else begin
      if (ctl_i.in_open) begin
        in_valid_q <= ctl_i.accept;
      end
      if (ctl_i.mid_open) begin
        mid_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      in_q <= item_i;
    end
    if (ctl_i.mid_open && in_valid_q) begin
      mid_q <= mid_d;
    end
  end

  // magnitude of the scroll amount and one shared reciprocal multiply
  assign neg      = in_q.scroll_amount[31];
  assign mag_in   = neg ? 32'(~in_q.scroll_amount + 32'sd1) : in_q.scroll_amount;
  assign recip    = (in_q.operation == pest_pkg::OP_V120) ? pest_pkg::RECIP15
                                                          : pest_pkg::RECIP5;
  assign prod     = {32'd0, mag_in} * {32'd0, recip};
  assign q5       = prod[63:34];
  assign q15      = prod[63:35];
  // remainders from the low bits only: 5q = 4q + q, 15q = 16q - q
  assign r5       = 3'(mag_in[2:0] - 3'({q5[0], 2'b00} + q5[2:0]));
  assign r15      = 4'(mag_in[3:0] + q15[3:0]);
  assign vertical = !in_q.scroll_axis;

  always_comb begin
    mid_d         = '0;
    mid_d.kind    = pest_pkg::K_NONE;
    mid_d.pressed = in_q.pressed;
    // truncate 24.8 toward zero
    mid_d.pos_x   = 24'(in_q.pos_x_fixed[31:8]
                    + {23'd0, in_q.pos_x_fixed[31] && (in_q.pos_x_fixed[7:0] != 8'd0)});
    mid_d.pos_y   = 24'(in_q.pos_y_fixed[31:8]
                    + {23'd0, in_q.pos_y_fixed[31] && (in_q.pos_y_fixed[7:0] != 8'd0)});

    case (in_q.operation)
      pest_pkg::OP_CONT: mag = {11'd0, q5, pest_pkg::frac5(r5)};
      pest_pkg::OP_DISC: mag = {mag_in, 16'd0};
      default:           mag = {6'd0, q15, pest_pkg::frac15(r15)};
    endcase
    // scroll is positive up, so the contribution has the opposite sign
    mid_d.delta = neg ? $signed({1'b0, mag}) : -$signed({1'b0, mag});

    case (in_q.operation)
      pest_pkg::OP_MOTION: mid_d.kind = pest_pkg::K_MOTION;
      pest_pkg::OP_BUTTON: begin
        case (in_q.button_code)
          pest_pkg::CODE_LEFT: begin
            mid_d.kind    = pest_pkg::K_BUTTON;
            mid_d.btn_idx = pest_pkg::IDX_LEFT;
          end
          pest_pkg::CODE_RIGHT: begin
            mid_d.kind    = pest_pkg::K_BUTTON;
            mid_d.btn_idx = pest_pkg::IDX_RIGHT;
          end
          pest_pkg::CODE_MIDDLE: begin
            mid_d.kind    = pest_pkg::K_BUTTON;
            mid_d.btn_idx = pest_pkg::IDX_MIDDLE;
          end
          default: mid_d.kind = pest_pkg::K_NONE;
        endcase
      end
      pest_pkg::OP_CONT:  mid_d.kind = vertical ? pest_pkg::K_CONT : pest_pkg::K_NONE;
      pest_pkg::OP_DISC,
      pest_pkg::OP_V120:  mid_d.kind = vertical ? pest_pkg::K_DISC : pest_pkg::K_NONE;
      pest_pkg::OP_FRAME: mid_d.kind = pest_pkg::K_FRAME;
      pest_pkg::OP_POLL:  mid_d.kind = pest_pkg::K_POLL;
      default:            mid_d.kind = pest_pkg::K_NONE;
    endcase
  end

  assign stat_o.in_valid  = in_valid_q;
  assign stat_o.mid_valid = mid_valid_q;
  assign stat_o.mid_poll  = (mid_q.kind == pest_pkg::K_POLL);
  assign mid_o            = mid_q;

endmodule

// ----- design/pest_state.sv -----
// state stage: position, buttons, scroll accumulator and the result register
// depends on pest_pkg
module pest_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                retire_i,
  input  pest_pkg::mid_t      mid_i,
  input  logic [7:0]          auto_release_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic signed [23:0]  pointer_x_o,
  output logic signed [23:0]  pointer_y_o,
  output logic                left_down_o,
  output logic                right_down_o,
  output logic                middle_down_o,
  output logic signed [31:0]  scroll_delta_o
);

  logic signed [23:0] pos_x_q, pos_x_d;
  logic signed [23:0] pos_y_q, pos_y_d;
  logic [pest_pkg::NUM_BTN-1:0] held_q, held_d;
  logic [8:0]         cnt_q [pest_pkg::NUM_BTN];
  logic [8:0]         cnt_d [pest_pkg::NUM_BTN];
  logic signed [47:0] sum_q, sum_d;
  logic               disc_q, disc_d;

  logic               out_valid_q;
  logic signed [23:0] out_x_q, out_y_q;
  logic [pest_pkg::NUM_BTN-1:0] out_btn_q;
  logic signed [31:0] out_scroll_q;

  logic signed [49:0] sum_ext;
  logic signed [47:0] sum_sat;
  logic signed [31:0] scroll_sat;
  logic [8:0]         cnt_inc;
  logic               is_poll;

  // saturating accumulate
  always_comb begin
    sum_ext = {{2{sum_q[47]}}, sum_q} + {mid_i.delta[48], mid_i.delta};
    if (sum_ext[49:47] == 3'b000 || sum_ext[49:47] == 3'b111) begin
      sum_sat = sum_ext[47:0];
    end else if (sum_ext[49]) begin
      sum_sat = {1'b1, 47'd0};
    end else begin
      sum_sat = {1'b0, {47{1'b1}}};
    end
    if (sum_q[47:31] == 17'd0 || sum_q[47:31] == {17{1'b1}}) begin
      scroll_sat = sum_q[31:0];
    end else if (sum_q[47]) begin
      scroll_sat = {1'b1, 31'd0};
    end else begin
      scroll_sat = {1'b0, {31{1'b1}}};
    end
  end

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    held_d  = held_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    disc_d  = disc_q;
    cnt_inc = '0;
    is_poll = 1'b0;
    if (retire_i) begin
      case (mid_i.kind)
        pest_pkg::K_MOTION: begin
          pos_x_d = mid_i.pos_x;
          pos_y_d = mid_i.pos_y;
        end
        pest_pkg::K_BUTTON: begin
          for (int i = 0; i < pest_pkg::NUM_BTN; i++) begin
            if (mid_i.btn_idx == 2'(i)) begin
              held_d[i] = mid_i.pressed;
              cnt_d[i]  = {8'd0, mid_i.pressed};
            end
          end
        end
        pest_pkg::K_CONT: begin
          if (!disc_q) begin
            sum_d = sum_sat;
          end
        end
        pest_pkg::K_DISC: begin
          disc_d = 1'b1;
          sum_d  = sum_sat;
        end
        pest_pkg::K_FRAME: disc_d = 1'b0;
        pest_pkg::K_POLL: begin
          is_poll = 1'b1;
          sum_d   = '0;
          for (int i = 0; i < pest_pkg::NUM_BTN; i++) begin
            if (held_q[i]) begin
              cnt_inc = 9'(cnt_q[i] + 9'd1);
              if (cnt_inc > {1'b0, auto_release_i}) begin
                held_d[i] = 1'b0;
                cnt_d[i]  = '0;
              end else begin
                cnt_d[i]  = cnt_inc;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      held_q      <= '0;
      sum_q       <= '0;
      disc_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < pest_pkg::NUM_BTN; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      held_q  <= held_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      disc_q  <= disc_d;
      if (is_poll) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_poll) begin
      out_x_q      <= pos_x_q;
      out_y_q      <= pos_y_q;
      out_btn_q    <= held_d;
      out_scroll_q <= scroll_sat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pointer_x_o    = out_x_q;
  assign pointer_y_o    = out_y_q;
  assign left_down_o    = out_btn_q[pest_pkg::IDX_LEFT];
  assign right_down_o   = out_btn_q[pest_pkg::IDX_RIGHT];
  assign middle_down_o  = out_btn_q[pest_pkg::IDX_MIDDLE];
  assign scroll_delta_o = out_scroll_q;

endmodule

// ----- design/pointer_event_state_tracker.sv -----
// top level of the pointer event state tracker
// depends on pest_pkg, pest_apb_regs, pest_front and pest_state
//
// takes one pointer event per clock cycle while in_stall_o is low and
// answers each poll with one result transfer carrying position, button flags
// and scroll since the last poll; every other event updates internal state and
// produces no transfer. an event passes three registers: the input register, a
// mid register behind the scroll scaling (one shared 32x32 reciprocal multiply
// for the divide by ten and by 120), and the state / result register where the
// accumulator, buttons and position are updated. all state is touched in that
// last stage only, so events of any kind follow each other in consecutive
// cycles while the input side does not stall. it stalls only while a poll
// waits in the last stage behind a result that the output side stalls and the
// input register is occupied; non-poll events keep draining past a held
// result. the auto-release count is written over the apb port at byte
// address 0 (reset value 3) and should only be changed while no events are in
// flight.
module pointer_event_state_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  operation_i,
  input  logic signed [31:0]          pos_x_fixed_i,
  input  logic signed [31:0]          pos_y_fixed_i,
  input  logic [9:0]                  button_code_i,
  input  logic                        pressed_i,
  input  logic                        scroll_axis_i,
  input  logic signed [31:0]          scroll_amount_i,

  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [23:0]          pointer_x_o,
  output logic signed [23:0]          pointer_y_o,
  output logic                        left_down_o,
  output logic                        right_down_o,
  output logic                        middle_down_o,
  output logic signed [31:0]          scroll_delta_o,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pest_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  pest_pkg::item_t       item;
  pest_pkg::pipe_ctl_t   ctl;
  pest_pkg::front_stat_t stat;
  pest_pkg::mid_t        mid;
  logic [7:0]            auto_release;
  logic                  out_free;
  logic                  retire;

  // payload bundle for the input register
  assign item.operation     = operation_i;
  assign item.pos_x_fixed   = pos_x_fixed_i;
  assign item.pos_y_fixed   = pos_y_fixed_i;
  assign item.button_code   = button_code_i;
  assign item.pressed       = pressed_i;
  assign item.scroll_axis   = scroll_axis_i;
  assign item.scroll_amount = scroll_amount_i;

  // result register free, or its result is taken this cycle
  assign out_free     = !out_valid_o || !out_stall_i;
  // last stage retires unless it is a poll with nowhere to put its result
  assign retire       = stat.mid_valid && (!stat.mid_poll || out_free);
  assign ctl.mid_open = !stat.mid_valid || retire;
  assign ctl.in_open  = !stat.in_valid || ctl.mid_open;
  assign ctl.accept   = in_valid_i && ctl.in_open;
  assign in_stall_o   = !ctl.in_open;

  pest_apb_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .auto_release_o (auto_release)
  );

  pest_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .item_i (item),
    .stat_o (stat),
    .mid_o  (mid)
  );

  pest_state u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .retire_i       (retire),
    .mid_i          (mid),
    .auto_release_i (auto_release),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .pointer_x_o    (pointer_x_o),
    .pointer_y_o    (pointer_y_o),
    .left_down_o    (left_down_o),
    .right_down_o   (right_down_o),
    .middle_down_o  (middle_down_o),
    .scroll_delta_o (scroll_delta_o)
  );

endmodule
